/* sv/i2csbr_pkg.sv */
// Shared constants and controller/datapath interface types for the I2C slave responder.
`timescale 1ns / 1ps

package i2csbr_pkg;

  // receive store and reply buffer geometry
  localparam int BUF_DEPTH = 16;
  localparam int IDX_W     = $clog2(BUF_DEPTH);
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam int POS_W     = 4;
  localparam int REPLY_N   = 16;
  localparam int REPLY_W   = $clog2(REPLY_N);
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_LO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_HI = 1'b1;

  localparam logic [CFG_W-1:0] REPLY_LO_RST = 64'h0706_0504_0302_0100;
  localparam logic [CFG_W-1:0] REPLY_HI_RST = 64'h0F0E_0D0C_0B0A_0908;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TX    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RX    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FAULT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd4;

  // status word: {D, 0, S, R/W, 0, BF}
  localparam logic [5:0] STATUS_MASK    = 6'b10_1101;
  localparam logic [5:0] ST_WRITE_ADDR  = 6'b00_1001;
  localparam logic [5:0] ST_WRITE_DATA  = 6'b10_1001;
  localparam logic [5:0] READ_ADDR_MASK = 6'b10_1100;
  localparam logic [5:0] ST_READ_DATA   = 6'b10_1100;
  localparam logic [5:0] ST_READ_ADDR   = 6'b00_1100;

  typedef struct packed {
    logic cap_in;     // latch the accepted word
    logic load_evt;   // single-result item: update state, load output
    logic take_start; // host take: reset read index
    logic take_read;  // read receive store at read index
    logic load_take;  // load delivered byte into output, advance index
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a word this cycle
    logic is_take;    // latched item streams the receive store
    logic take_last;  // read index points at the final held byte
  } dp_status_t;

endpackage

/* sv/i2c_slave_buffer_responder_unit.sv */
// Top level: I2C slave event responder with receive store and reply buffer.
// Bus event: captured in S_IDLE, then decoded in S_DECODE, which registers its result once the output is free.
// Host take of N held bytes: one store read (S_TAKE_RD) per delivered byte (S_TAKE_OUT).
// A pending result stalls decode of the next word, and no new word is accepted until that decode is done.
// Synchronous active-low reset clears counts, reply index, fault flag and reply
// registers to their defaults; receive store contents are not cleared.
`timescale 1ns / 1ps

module i2c_slave_buffer_responder_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [i2csbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2csbr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic                                in_data_not_address,
  input  logic                                in_start_seen,
  input  logic                                in_read_not_write,
  input  logic                                in_buffer_full,
  input  logic                                in_stop_seen,
  input  logic                                in_master_nack,
  input  logic [7:0]                          in_bus_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [i2csbr_pkg::KIND_W-1:0]       out_result_kind,
  output logic [7:0]                          out_byte,
  output logic                                out_release_clock,
  output logic [i2csbr_pkg::POS_W-1:0]        out_byte_position,
  output logic                                out_last
);

  i2csbr_pkg::dp_cmd_t    cmd;
  i2csbr_pkg::dp_status_t status;

  i2csbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  i2csbr_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_operation        (in_operation),
    .in_data_not_address (in_data_not_address),
    .in_start_seen       (in_start_seen),
    .in_read_not_write   (in_read_not_write),
    .in_buffer_full      (in_buffer_full),
    .in_stop_seen        (in_stop_seen),
    .in_master_nack      (in_master_nack),
    .in_bus_byte         (in_bus_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_byte            (out_byte),
    .out_release_clock   (out_release_clock),
    .out_byte_position   (out_byte_position),
    .out_last            (out_last)
  );

  // an accepted word is always decoded before the next one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while previous word still in decode");

  // only delivered receive bytes can be non-final or carry a position
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != i2csbr_pkg::KIND_RX) |->
      out_last && (out_byte_position == '0))
    else $error("single-result word with position or without last");

  // a fault never releases the bus clock
  a_fault_holds_clock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == i2csbr_pkg::KIND_FAULT) |-> !out_release_clock)
    else $error("fault result released the clock");

  // the controller issues at most one datapath command at a time
  a_take_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.cap_in, cmd.load_evt, cmd.take_start, cmd.take_read, cmd.load_take}))
    else $error("controller issued overlapping datapath commands");

endmodule

/* sv/i2csbr_dp.sv */
// Datapath: item latch, event classification, receive store, reply buffer, output register.
`timescale 1ns / 1ps

module i2csbr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  i2csbr_pkg::dp_cmd_t                 cmd,
  output i2csbr_pkg::dp_status_t              status,
  input  logic                                cfg_wr_en,
  input  logic [i2csbr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2csbr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                in_operation,
  input  logic                                in_data_not_address,
  input  logic                                in_start_seen,
  input  logic                                in_read_not_write,
  input  logic                                in_buffer_full,
  input  logic                                in_stop_seen,
  input  logic                                in_master_nack,
  input  logic [7:0]                          in_bus_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [i2csbr_pkg::KIND_W-1:0]       out_result_kind,
  output logic [7:0]                          out_byte,
  output logic                                out_release_clock,
  output logic [i2csbr_pkg::POS_W-1:0]        out_byte_position,
  output logic                                out_last
);

  typedef enum logic [2:0] {
    EV_FAULT,
    EV_EMPTY,
    EV_TAKE,
    EV_WADDR,
    EV_WDATA,
    EV_RADDR,
    EV_RDATA,
    EV_IDLE
  } ev_class_t;

  // latched item
  logic       op_r;
  logic [5:0] stat_r;
  logic       stop_r;
  logic       nack_r;
  logic [7:0] byte_r;

  // architectural state
  logic [i2csbr_pkg::CNT_W-1:0]   rx_count_r;
  logic [i2csbr_pkg::IDX_W-1:0]   tx_idx_r;
  logic                           faulted_r;
  logic [i2csbr_pkg::CFG_W-1:0]   reply_lo_r;
  logic [i2csbr_pkg::CFG_W-1:0]   reply_hi_r;
  logic [7:0]                     rx_mem [i2csbr_pkg::BUF_DEPTH];

  // host take walk
  logic [i2csbr_pkg::IDX_W-1:0]   take_idx_r;
  logic [7:0]                     rd_data_r;

  // output register
  logic                             out_valid_r;
  logic [i2csbr_pkg::KIND_W-1:0]    out_kind_r;
  logic [7:0]                       out_byte_r;
  logic                             out_rel_r;
  logic [i2csbr_pkg::POS_W-1:0]     out_pos_r;
  logic                             out_last_r;

  ev_class_t                        ev_class;
  logic                             dna;
  logic                             out_free;
  logic [i2csbr_pkg::REPLY_W-1:0]   tx_sel;
  logic [7:0]                       tx_byte;
  logic [2*i2csbr_pkg::CFG_W-1:0]   reply_all;
  logic [i2csbr_pkg::IDX_W:0]       tx_inc;
  logic [i2csbr_pkg::IDX_W-1:0]     tx_idx_nxt;
  logic                             rx_room;
  logic                             send;
  logic [i2csbr_pkg::KIND_W-1:0]    evt_kind;
  logic                             evt_rel;

  assign dna = stat_r[5];

  always_comb begin
    if (faulted_r) begin
      ev_class = EV_FAULT;
    end else if (op_r) begin
      ev_class = (rx_count_r == '0) ? EV_EMPTY : EV_TAKE;
    end else if ((stat_r & i2csbr_pkg::STATUS_MASK) == i2csbr_pkg::ST_WRITE_ADDR) begin
      ev_class = EV_WADDR;
    end else if ((stat_r & i2csbr_pkg::STATUS_MASK) == i2csbr_pkg::ST_WRITE_DATA) begin
      ev_class = EV_WDATA;
    end else if ((stat_r & i2csbr_pkg::READ_ADDR_MASK) == i2csbr_pkg::ST_READ_ADDR) begin
      ev_class = EV_RADDR;
    end else if ((stat_r & i2csbr_pkg::STATUS_MASK) == i2csbr_pkg::ST_READ_DATA) begin
      ev_class = EV_RDATA;
    end else if (stop_r || (dna && nack_r)) begin
      ev_class = EV_IDLE;
    end else begin
      ev_class = EV_FAULT;
    end
  end

  // reply byte: a read address always starts at byte zero
  assign reply_all = {reply_hi_r, reply_lo_r};
  assign tx_sel    = (ev_class == EV_RADDR) ? '0 : i2csbr_pkg::REPLY_W'(tx_idx_r);
  assign tx_byte   = reply_all[{tx_sel, 3'b000} +: 8];
  assign tx_inc    = (i2csbr_pkg::IDX_W + 1)'(tx_sel) + 1'b1;
  assign tx_idx_nxt = (tx_inc >= (i2csbr_pkg::IDX_W + 1)'(i2csbr_pkg::BUF_DEPTH)) ?
                      '0 : tx_inc[i2csbr_pkg::IDX_W-1:0];
  assign rx_room   = rx_count_r < i2csbr_pkg::CNT_W'(i2csbr_pkg::BUF_DEPTH);
  assign send      = (ev_class == EV_RADDR) || ((ev_class == EV_RDATA) && !nack_r);

  always_comb begin
    evt_kind = i2csbr_pkg::KIND_NONE;
    evt_rel  = 1'b0;
    case (ev_class)
      EV_FAULT: evt_kind = i2csbr_pkg::KIND_FAULT;
      EV_EMPTY: evt_kind = i2csbr_pkg::KIND_EMPTY;
      EV_WADDR, EV_WDATA: evt_rel = 1'b1;
      EV_RADDR, EV_RDATA: begin
        evt_rel  = 1'b1;
        evt_kind = send ? i2csbr_pkg::KIND_TX : i2csbr_pkg::KIND_NONE;
      end
      default: begin
        evt_kind = i2csbr_pkg::KIND_NONE;
        evt_rel  = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  assign status.out_free  = out_free;
  assign status.is_take   = (ev_class == EV_TAKE);
  assign status.take_last =
    (i2csbr_pkg::CNT_W'(take_idx_r) + i2csbr_pkg::CNT_W'(1)) == rx_count_r;

  // item latch and take walk payload
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      op_r   <= in_operation;
      stat_r <= {in_data_not_address, 1'b0, in_start_seen, in_read_not_write,
                 1'b0, in_buffer_full};
      stop_r <= in_stop_seen;
      nack_r <= in_master_nack;
      byte_r <= in_bus_byte;
    end
    if (cmd.take_read) begin
      rd_data_r <= rx_mem[take_idx_r];
    end
  end

  // receive store
  always_ff @(posedge clk) begin
    if (cmd.load_evt && (ev_class == EV_WDATA) && rx_room) begin
      rx_mem[rx_count_r[i2csbr_pkg::IDX_W-1:0]] <= byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_count_r <= '0;
      tx_idx_r   <= '0;
      faulted_r  <= 1'b0;
      reply_lo_r <= i2csbr_pkg::REPLY_LO_RST;
      reply_hi_r <= i2csbr_pkg::REPLY_HI_RST;
      take_idx_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          i2csbr_pkg::REG_REPLY_LO: reply_lo_r <= cfg_data;
          i2csbr_pkg::REG_REPLY_HI: reply_hi_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_evt) begin
        case (ev_class)
          EV_FAULT: faulted_r <= 1'b1;
          EV_WADDR: rx_count_r <= '0;
          EV_WDATA: begin
            if (rx_room) rx_count_r <= rx_count_r + 1'b1;
          end
          EV_RADDR: begin
            rx_count_r <= '0;
            tx_idx_r   <= tx_idx_nxt;
          end
          EV_RDATA: begin
            if (send) tx_idx_r <= tx_idx_nxt;
          end
          default: ;
        endcase
      end
      if (cmd.take_start) begin
        take_idx_r <= '0;
      end else if (cmd.load_take) begin
        take_idx_r <= take_idx_r + 1'b1;
        if (status.take_last) rx_count_r <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_evt || cmd.load_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_evt) begin
      out_kind_r <= evt_kind;
      out_byte_r <= send ? tx_byte : 8'h00;
      out_rel_r  <= evt_rel;
      out_pos_r  <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.load_take) begin
      out_kind_r <= i2csbr_pkg::KIND_RX;
      out_byte_r <= rd_data_r;
      out_rel_r  <= 1'b0;
      out_pos_r  <= i2csbr_pkg::POS_W'(take_idx_r);
      out_last_r <= status.take_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_byte          = out_byte_r;
  assign out_release_clock = out_rel_r;
  assign out_byte_position = out_pos_r;
  assign out_last          = out_last_r;

endmodule

/* sv/i2csbr_ctrl.sv */
// Controller: sequences item capture, single-result handling and the host-take walk.
`timescale 1ns / 1ps

module i2csbr_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  i2csbr_pkg::dp_status_t  status,
  output i2csbr_pkg::dp_cmd_t     cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_TAKE_RD,
    S_TAKE_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.is_take) begin
          cmd.take_start = 1'b1;
          state_nxt      = S_TAKE_RD;
        end else if (status.out_free) begin
          cmd.load_evt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_TAKE_RD: begin
        cmd.take_read = 1'b1;
        state_nxt     = S_TAKE_OUT;
      end
      S_TAKE_OUT: begin
        if (status.out_free) begin
          cmd.load_take = 1'b1;
          state_nxt     = status.take_last ? S_IDLE : S_TAKE_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sim/tb_top.sv */
// Testbench for the I2C slave event responder: predicts every result word and checks it.
`timescale 1ns / 1ps

module tb_top;

  localparam int STORE_DEPTH = i2csbr_pkg::BUF_DEPTH;
  localparam int IDLE_PCT    = 17;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic       op;
    logic       dna;
    logic       start;
    logic       rnw;
    logic       bf;
    logic       stop;
    logic       nack;
    logic [7:0] data;
  } bus_word_t;

  typedef struct packed {
    logic [i2csbr_pkg::KIND_W-1:0] kind;
    logic [7:0]                    data;
    logic                          rel;
    logic [i2csbr_pkg::POS_W-1:0]  pos;
    logic                          last;
  } result_t;

  typedef enum int {
    EV_WRITE_ADDR, EV_WRITE_DATA, EV_READ_ADDR, EV_READ_DATA, EV_IDLE, EV_FAULT
  } bus_event_e;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_wr_en;
  logic [i2csbr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [i2csbr_pkg::CFG_W-1:0]     cfg_data;
  logic                             in_valid;
  logic                             in_ready;
  logic                             in_operation;
  logic                             in_data_not_address;
  logic                             in_start_seen;
  logic                             in_read_not_write;
  logic                             in_buffer_full;
  logic                             in_stop_seen;
  logic                             in_master_nack;
  logic [7:0]                       in_bus_byte;
  logic                             out_valid;
  logic                             out_ready;
  logic [i2csbr_pkg::KIND_W-1:0]    out_result_kind;
  logic [7:0]                       out_byte;
  logic                             out_release_clock;
  logic [i2csbr_pkg::POS_W-1:0]     out_byte_position;
  logic                             out_last;

  // predictor state
  logic [63:0] reply_lo;
  logic [63:0] reply_hi;
  logic [7:0]  rx_mem [STORE_DEPTH];
  int          held_cnt;
  int          tx_idx;
  bit          faulted_q;

  result_t response_q[$];
  int      errors;
  int      words_sent;
  int      results_seen;
  int      reg_writes;
  bit      no_idle;
  bit      hold_req;

  i2c_slave_buffer_responder_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_data_not_address (in_data_not_address),
    .in_start_seen       (in_start_seen),
    .in_read_not_write   (in_read_not_write),
    .in_buffer_full      (in_buffer_full),
    .in_stop_seen        (in_stop_seen),
    .in_master_nack      (in_master_nack),
    .in_bus_byte         (in_bus_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_byte            (out_byte),
    .out_release_clock   (out_release_clock),
    .out_byte_position   (out_byte_position),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d result words still pending", response_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic bus_event_e classify(bus_word_t w);
    if (!w.dna && w.start && !w.rnw && w.bf) return EV_WRITE_ADDR;
    if (w.dna && w.start && !w.rnw && w.bf) return EV_WRITE_DATA;
    if (!w.dna && w.start && w.rnw) return EV_READ_ADDR;     // BF is don't-care here
    if (w.dna && w.start && w.rnw && !w.bf) return EV_READ_DATA;
    if (w.stop || (w.dna && w.nack)) return EV_IDLE;
    return EV_FAULT;
  endfunction

  function automatic logic [7:0] next_reply_byte();
    logic [127:0] reply_all;
    logic [7:0]   b;
    reply_all = {reply_hi, reply_lo};
    b = reply_all[tx_idx*8 +: 8];
    tx_idx = tx_idx + 1;
    if (tx_idx >= STORE_DEPTH) tx_idx = 0;
    return b;
  endfunction

  function automatic void queue_result(logic [i2csbr_pkg::KIND_W-1:0] kind, logic [7:0] data,
                                       logic rel, logic [i2csbr_pkg::POS_W-1:0] pos,
                                       logic last);
    result_t r;
    r.kind = kind;
    r.data = data;
    r.rel  = rel;
    r.pos  = pos;
    r.last = last;
    response_q.push_back(r);
  endfunction

  task automatic predict_responses(bus_word_t w);
    if (faulted_q) begin
      queue_result(i2csbr_pkg::KIND_FAULT, 8'h00, 1'b0, '0, 1'b1);
      return;
    end
    if (w.op) begin
      if (held_cnt == 0) begin
        queue_result(i2csbr_pkg::KIND_EMPTY, 8'h00, 1'b0, '0, 1'b1);
      end else begin
        for (int i = 0; i < held_cnt; i++)
          queue_result(i2csbr_pkg::KIND_RX, rx_mem[i], 1'b0, i[i2csbr_pkg::POS_W-1:0],
                       i == held_cnt - 1);
        held_cnt = 0;
      end
      return;
    end
    case (classify(w))
      EV_WRITE_ADDR: begin
        held_cnt = 0;
        queue_result(i2csbr_pkg::KIND_NONE, 8'h00, 1'b1, '0, 1'b1);
      end
      EV_WRITE_DATA: begin
        // full store drops the byte but still releases the clock
        if (held_cnt < STORE_DEPTH) begin
          rx_mem[held_cnt] = w.data;
          held_cnt++;
        end
        queue_result(i2csbr_pkg::KIND_NONE, 8'h00, 1'b1, '0, 1'b1);
      end
      EV_READ_ADDR: begin
        tx_idx   = 0;
        held_cnt = 0;
        queue_result(i2csbr_pkg::KIND_TX, next_reply_byte(), 1'b1, '0, 1'b1);
      end
      EV_READ_DATA: begin
        if (!w.nack) queue_result(i2csbr_pkg::KIND_TX, next_reply_byte(), 1'b1, '0, 1'b1);
        else queue_result(i2csbr_pkg::KIND_NONE, 8'h00, 1'b1, '0, 1'b1);
      end
      EV_IDLE: queue_result(i2csbr_pkg::KIND_NONE, 8'h00, 1'b0, '0, 1'b1);
      default: begin
        faulted_q = 1'b1;
        queue_result(i2csbr_pkg::KIND_FAULT, 8'h00, 1'b0, '0, 1'b1);
      end
    endcase
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic bus_word_t rand_word(bus_event_e cls);
    bus_word_t w;
    do begin
      w = bus_word_t'(15'($urandom));
      w.op = 1'b0;
    end while (classify(w) != cls);
    return w;
  endfunction

  function automatic bus_word_t rand_take();
    bus_word_t w;
    w = bus_word_t'(15'($urandom));
    w.op = 1'b1;
    return w;
  endfunction

  // enter and leave on a falling edge; valid is left high for a back-to-back word
  task automatic send_word(bus_word_t w);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_operation        <= w.op;
    in_data_not_address <= w.dna;
    in_start_seen       <= w.start;
    in_read_not_write   <= w.rnw;
    in_buffer_full      <= w.bf;
    in_stop_seen        <= w.stop;
    in_master_nack      <= w.nack;
    in_bus_byte         <= w.data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_responses(w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (response_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [i2csbr_pkg::CFG_IDX_W-1:0] idx,
                           logic [i2csbr_pkg::CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == i2csbr_pkg::REG_REPLY_LO) reply_lo = value;
    else reply_hi = value;
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_reply(logic [63:0] lo, logic [63:0] hi);
    write_reg(i2csbr_pkg::REG_REPLY_LO, lo);
    write_reg(i2csbr_pkg::REG_REPLY_HI, hi);
  endtask

  task automatic write_txn(int n);
    send_word(rand_word(EV_WRITE_ADDR));
    repeat (n) send_word(rand_word(EV_WRITE_DATA));
    send_word(rand_word(EV_IDLE));
  endtask

  task automatic read_txn(int n);
    bus_word_t w;
    send_word(rand_word(EV_READ_ADDR));
    repeat (n) begin
      w = rand_word(EV_READ_DATA);
      w.nack = 1'b0;
      send_word(w);
    end
    w = rand_word(EV_READ_DATA);
    w.nack = 1'b1;
    send_word(w);
    send_word(rand_word(EV_IDLE));
  endtask

  // mostly whole transactions; lengths past the store depth hit overflow and reply wrap
  task automatic random_traffic(int count);
    int target;
    int sel;
    int len;
    target = words_sent + count;
    while (words_sent < target) begin
      sel = $urandom_range(99);
      len = ($urandom_range(9) < 8) ? $urandom_range(6) : $urandom_range(14, 20);
      if (sel < 35) write_txn(len);
      else if (sel < 65) read_txn(len);
      else if (sel < 85) send_word(rand_take());
      else send_word(rand_word(bus_event_e'($urandom_range(EV_IDLE))));
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_reply_defaults();
    bus_word_t w;
    send_word(rand_word(EV_READ_ADDR));
    w = rand_word(EV_READ_DATA);
    w.nack = 1'b0;
    send_word(w);
    send_word(w);
    w.nack = 1'b1;
    send_word(w);
    send_word(rand_word(EV_IDLE));
  endtask

  task automatic test_receive_take();
    bus_word_t w;
    send_word(rand_take());
    w = rand_word(EV_WRITE_ADDR);
    w.data = 8'hFF;
    send_word(w);
    w = rand_word(EV_WRITE_DATA);
    w.data = 8'h00;
    send_word(w);
    w.data = 8'hFF;
    send_word(w);
    w.data = 8'hA5;
    send_word(w);
    send_word(rand_word(EV_IDLE));
    send_word(rand_take());
    send_word(rand_take());
  endtask

  task automatic test_quiet_events();
    bus_word_t w;
    // data NACK without a stop
    w = '0;
    w.dna  = 1'b1;
    w.nack = 1'b1;
    send_word(w);
    // stop with everything else low
    w = '0;
    w.stop = 1'b1;
    send_word(w);
    // read address with BF set still counts as read address
    w = rand_word(EV_READ_ADDR);
    w.bf = 1'b1;
    send_word(w);
    wait_drained();
  endtask

  task automatic test_random_defaults();
    random_traffic(85);
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    set_reply('1, '0);
    no_idle = 1'b1;
    random_traffic(90);
    wait_drained();
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure();
    set_reply({$urandom, $urandom}, {$urandom, $urandom});
    hold_req = 1'b1;
    write_txn(19);
    read_txn(18);
    send_word(rand_take());
    random_traffic(60);
    wait_drained();
  endtask

  task automatic test_random_patterns();
    set_reply('0, '1);
    random_traffic(55);
    wait_drained();
    set_reply({$urandom, $urandom}, {$urandom, $urandom});
    random_traffic(55);
    wait_drained();
  endtask

  // must run last: only reset clears the fault
  task automatic test_sticky_fault();
    bus_word_t w;
    w = rand_word(EV_FAULT);
    send_word(w);
    send_word(rand_take());
    send_word(rand_word(EV_WRITE_ADDR));
    send_word(rand_word(EV_READ_ADDR));
    send_word(rand_word(EV_IDLE));
    wait_drained();
  endtask

  // ---------------- result side ----------------

  initial begin : rx_ready_gen
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want != got) begin
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin : result_check
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        results_seen++;
        if (response_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word: expected none, got kind %0d byte %02h",
                   $time, out_result_kind, out_byte);
        end else begin
          want = response_q.pop_front();
          check_field("result_kind", 8'(want.kind), 8'(out_result_kind));
          check_field("out_byte", want.data, out_byte);
          check_field("release_clock", 8'(want.rel), 8'(out_release_clock));
          check_field("byte_position", 8'(want.pos), 8'(out_byte_position));
          check_field("last", 8'(want.last), 8'(out_last));
        end
      end
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    in_valid            = 1'b0;
    in_operation        = 1'b0;
    in_data_not_address = 1'b0;
    in_start_seen       = 1'b0;
    in_read_not_write   = 1'b0;
    in_buffer_full      = 1'b0;
    in_stop_seen        = 1'b0;
    in_master_nack      = 1'b0;
    in_bus_byte         = '0;
    no_idle             = 1'b0;
    hold_req            = 1'b0;
    errors              = 0;
    words_sent          = 0;
    results_seen        = 0;
    reg_writes          = 0;
    reply_lo            = i2csbr_pkg::REPLY_LO_RST;
    reply_hi            = i2csbr_pkg::REPLY_HI_RST;
    held_cnt            = 0;
    tx_idx              = 0;
    faulted_q           = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reply_defaults();
    test_receive_take();
    test_quiet_events();
    test_random_defaults();
    test_random_no_idle();
    test_backpressure();
    test_random_patterns();
    test_sticky_fault();

    repeat (40) @(posedge clk);
    $display("Sent %0d bus/host words, checked %0d result words, %0d register writes",
             words_sent, results_seen, reg_writes);
    $display("Covered write/read transactions, store overflow, reply wrap, stalls, sticky fault");
    if (errors == 0 && response_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Errors: %0d, result words never seen: %0d", errors, response_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
